// ===== rtl/ms_pkg.sv =====
`timescale 1ns / 1ps

package ms_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int MAX_ELEMENTS = 64;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [CNT_W-1:0]             count_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

   // per-cycle control shared by every cell of the chain
   typedef struct packed {
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== rtl/ms_cell.sv =====
`timescale 1ns / 1ps

module ms_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ms_pkg::cell_ctrl_type ctrl,
   input  ms_pkg::data_type      ins_val,
   input  logic                  ins_vld,
   input  ms_pkg::data_type      nbr_val,
   input  logic                  nbr_vld,
   output ms_pkg::data_type      val,
   output logic                  vld,
   output ms_pkg::data_type      pass_val,
   output logic                  pass_vld
);

   ms_pkg::data_type val_ff, val_in;
   logic             vld_ff, vld_in;
   ms_pkg::data_type pass_val_ff, pass_val_in;
   logic             pass_vld_ff, pass_vld_in;

   always_comb begin
      val_in      = val_ff;
      vld_in      = vld_ff;
      pass_val_in = pass_val_ff;
      pass_vld_in = 1'b0;
      priority if (ctrl.shift) begin
         // drain: take the neighbor's value from the right
         val_in = nbr_val;
         vld_in = nbr_vld;
      end else if (ins_vld) begin
         if (!vld_ff || (ins_val < val_ff)) begin
            // keep the smaller one, hand the held value on
            val_in      = ins_val;
            vld_in      = 1'b1;
            pass_val_in = val_ff;
            pass_vld_in = vld_ff;
         end else begin
            // ties go behind the held value
            pass_val_in = ins_val;
            pass_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= 1'b0;
         pass_vld_ff <= 1'b0;
      end else begin
         vld_ff      <= vld_in;
         pass_vld_ff <= pass_vld_in;
      end
      val_ff      <= val_in;
      pass_val_ff <= pass_val_in;
   end

   assign val      = val_ff;
   assign vld      = vld_ff;
   assign pass_val = pass_val_ff;
   assign pass_vld = pass_vld_ff;

endmodule

// ===== rtl/merge_sorter.sv =====
`timescale 1ns / 1ps
// channel   | ports                                          | direction
// ----------+------------------------------------------------+----------
// request   | req_valid req_ready req_value req_last         | in
// result    | rsp_valid rsp_ready rsp_sorted_value            | out
//           | rsp_final_res rsp_overflow                     |
//
// each request taken enters cell 0 of a 64-cell insertion chain and
// ripples right by one cell per cycle; new requests are taken while
// earlier ones still ripple. after the request marked last, the chain
// settles (until no cell is still handing a value on), then the set
// drains from cell 0 at one result per cycle while rsp_ready is high.
// req_ready is low from the last request until the final result is taken.
// synchronous reset empties the chain and clears count and overflow.

module merge_sorter (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [31:0]      req_value,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [31:0]      rsp_sorted_value,
   output logic                    rsp_final_res,
   output logic                    rsp_overflow
);

   localparam int N = ms_pkg::MAX_ELEMENTS;

   ms_pkg::state_type state_ff, state_in;
   ms_pkg::count_type count_ff, count_in;
   logic              ovf_ff, ovf_in;

   logic req_fire;
   logic rsp_fire;
   logic store;
   logic busy;

   ms_pkg::cell_ctrl_type ctrl;

   // chain wiring: per-cell held value and value handed to the right
   ms_pkg::data_type cell_val  [N];
   logic             cell_vld  [N];
   ms_pkg::data_type pass_val  [N];
   logic             pass_vld  [N];
   logic [N-1:0]     pass_vec;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   // requests beyond capacity are dropped but still end the set if last
   assign store    = req_fire && (count_ff < ms_pkg::count_type'(N));

   assign ctrl.shift = rsp_fire;

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_cell
         ms_pkg::data_type in_val;
         logic             in_vld;
         ms_pkg::data_type rt_val;
         logic             rt_vld;

         if (gi == 0) begin : g_head
            assign in_val = req_value;
            assign in_vld = store;
         end else begin : g_body
            assign in_val = pass_val[gi-1];
            assign in_vld = pass_vld[gi-1];
         end

         if (gi == N - 1) begin : g_tail
            assign rt_val = cell_val[gi];
            assign rt_vld = 1'b0;
         end else begin : g_mid
            assign rt_val = cell_val[gi+1];
            assign rt_vld = cell_vld[gi+1];
         end

         ms_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .ins_val  (in_val),
            .ins_vld  (in_vld),
            .nbr_val  (rt_val),
            .nbr_vld  (rt_vld),
            .val      (cell_val[gi]),
            .vld      (cell_vld[gi]),
            .pass_val (pass_val[gi]),
            .pass_vld (pass_vld[gi])
         );

         assign pass_vec[gi] = pass_vld[gi];
      end
   endgenerate

   // chain still moving values to the right
   assign busy = |pass_vec;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ms_pkg::ST_LOAD: begin
            if (req_fire && req_last) state_in = ms_pkg::ST_SETTLE;
         end
         ms_pkg::ST_SETTLE: begin
            if (!busy) state_in = ms_pkg::ST_DRAIN;
         end
         ms_pkg::ST_DRAIN: begin
            if (rsp_fire && (count_ff == ms_pkg::count_type'(1))) state_in = ms_pkg::ST_LOAD;
         end
         default: state_in = ms_pkg::ST_LOAD;
      endcase
   end

   // outputs and counters
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      unique case (state_ff)
         ms_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (store) count_in = count_ff + ms_pkg::count_type'(1);
            else if (req_fire) ovf_in = 1'b1;
         end
         ms_pkg::ST_SETTLE: begin
         end
         ms_pkg::ST_DRAIN: begin
            rsp_valid = 1'b1;
            if (rsp_fire) begin
               count_in = count_ff - ms_pkg::count_type'(1);
               if (count_ff == ms_pkg::count_type'(1)) ovf_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ms_pkg::ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // cell 0 holds the smallest remaining value
   assign rsp_sorted_value = cell_val[0];
   assign rsp_final_res    = (count_ff == ms_pkg::count_type'(1));
   assign rsp_overflow     = ovf_ff;

endmodule
